/* hdl/crcrc_pkg.sv */
// Shared types and the CRC-16 byte fold for the record CRC checker.
// No dependencies; used by crc16_record_checker_top, crcrc_in_reg and crcrc_core.
package crcrc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // One incoming request after the input register.
    typedef struct packed {
        logic [15:0] expected_crc;
        logic        record_end;
        logic        byte_present;
        logic [7:0]  data_byte;
    } t_item;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [15:0] mismatch_actual;
        logic [15:0] mismatch_expected;
        logic [31:0] failed_count;
        logic [31:0] passed_count;
        logic [31:0] checked_count;
        logic [15:0] computed_crc;
    } t_result;

    // MSB-first fold of one byte, poly 0x1021, no reflection.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

/* hdl/crc16_record_checker_top.sv */
// Record CRC checker: CRC-16 (init 0xFFFF, poly 0x1021) over record bytes.
// A closing request is held in the input register, then folded and compared into the
// result register.
// Throughput: one request per cycle; a closing request waits while a result is stalled.
// Reset (sync, active low): CRC to 0xFFFF, counts and mismatch values to 0.
// Depends on crcrc_pkg, crcrc_in_reg, crcrc_core.
module crc16_record_checker_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [23:0]   s_axis_tdata,   // data_byte[7:0], expected_crc[23:8]
    input  logic          s_axis_tlast,   // record_end
    input  logic          s_axis_tuser,   // byte_present
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,   // computed_crc[15:0], checked_count[47:16],
                                          // passed_count[79:48], failed_count[111:80],
                                          // mismatch_expected[127:112],
                                          // mismatch_actual[143:128]
    output logic          m_axis_tuser    // crc_ok
);

    logic               item_valid;
    logic               item_take;
    crcrc_pkg::t_item   item;
    crcrc_pkg::t_result result;

    crcrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tlast (s_axis_tlast),
        .i_tuser (s_axis_tuser),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    crcrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .o_take      (item_take),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_crc_ok    (m_axis_tuser),
        .o_result    (result)
    );

    assign m_axis_tdata = result;

endmodule

/* hdl/crcrc_in_reg.sv */
// Input register of the record CRC checker: captures one request per cycle while the held one is taken.
// Depends on crcrc_pkg.
module crcrc_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [23:0]          i_tdata,
    input  logic                 i_tlast,
    input  logic                 i_tuser,
    input  logic                 i_take,
    output logic                 o_valid,
    output crcrc_pkg::t_item     o_item
);

    logic             r_valid;
    crcrc_pkg::t_item r_item;
    crcrc_pkg::t_item n_item;

    // Room when empty or when the held request moves on this cycle.
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_item.data_byte    = i_tdata[7:0];
        n_item.expected_crc = i_tdata[23:8];
        n_item.byte_present = i_tuser;
        n_item.record_end   = i_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hdl/crcrc_core.sv */
// CRC fold, record compare, saturating counters and the result register.
// Depends on crcrc_pkg.
module crcrc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  crcrc_pkg::t_item     i_item,
    output logic                 o_take,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_crc_ok,
    output crcrc_pkg::t_result   o_result
);

    logic [15:0]        r_crc;
    logic [31:0]        r_checked;
    logic [31:0]        r_passed;
    logic [31:0]        r_failed;
    logic [15:0]        r_bad_exp;
    logic [15:0]        r_bad_act;
    logic               r_out_valid;
    logic               r_ok;
    crcrc_pkg::t_result r_result;

    logic [15:0]        n_crc;
    logic [31:0]        n_checked;
    logic [31:0]        n_passed;
    logic [31:0]        n_failed;
    logic [15:0]        n_bad_exp;
    logic [15:0]        n_bad_act;
    logic               n_ok;
    logic               out_free;
    logic               close;

    assign out_free = !r_out_valid || i_out_ready;
    // A non-closing byte never needs the result slot.
    assign o_take   = i_valid && (!i_item.record_end || out_free);
    assign close    = o_take && i_item.record_end;

    always_comb begin
        n_crc     = i_item.byte_present ? crcrc_pkg::crc_fold(r_crc, i_item.data_byte)
                                        : r_crc;
        n_ok      = (n_crc == i_item.expected_crc);
        n_checked = crcrc_pkg::sat_inc(r_checked);
        n_passed  = n_ok ? crcrc_pkg::sat_inc(r_passed) : r_passed;
        n_failed  = n_ok ? r_failed : crcrc_pkg::sat_inc(r_failed);
        n_bad_exp = n_ok ? r_bad_exp : i_item.expected_crc;
        n_bad_act = n_ok ? r_bad_act : n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= crcrc_pkg::CRC_INIT;
            r_checked <= '0;
            r_passed  <= '0;
            r_failed  <= '0;
            r_bad_exp <= '0;
            r_bad_act <= '0;
        end else if (close) begin
            r_crc     <= crcrc_pkg::CRC_INIT;
            r_checked <= n_checked;
            r_passed  <= n_passed;
            r_failed  <= n_failed;
            r_bad_exp <= n_bad_exp;
            r_bad_act <= n_bad_act;
        end else if (o_take) begin
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close) begin
            r_ok                       <= n_ok;
            r_result.computed_crc      <= n_crc;
            r_result.checked_count     <= n_checked;
            r_result.passed_count      <= n_passed;
            r_result.failed_count      <= n_failed;
            r_result.mismatch_expected <= n_bad_exp;
            r_result.mismatch_actual   <= n_bad_act;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_ok    = r_ok;
    assign o_result    = r_result;

endmodule

/* hdl/crcrc_checker.sv */
// Port-level checks for crc16_record_checker_top, attached by bind.
// Depends only on the top level's ports.
module crcrc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [143:0]  m_axis_tdata,
    input logic          m_axis_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Below saturation every checked record is either passed or failed.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[47:16] != 32'hFFFF_FFFF) |->
            ({1'b0, m_axis_tdata[47:16]} ==
             ({1'b0, m_axis_tdata[79:48]} + {1'b0, m_axis_tdata[111:80]})))
        else $error("checked count differs from passed plus failed");

    // A failed record latches its own values as the mismatch pair.
    a_fail_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[143:128] == m_axis_tdata[15:0]) &&
            (m_axis_tdata[127:112] != m_axis_tdata[15:0]) &&
            (m_axis_tdata[111:80] != 32'd0))
        else $error("failed record not latched");

    // A result always counts at least one record.
    a_checked_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:16] != 32'd0))
        else $error("result with zero checked count");

    // No result right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind crc16_record_checker_top crcrc_checker u_crcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/crc_verdict_monitor.sv */
`timescale 1ns / 100ps
// Monitor for the record CRC checker: watches both stream ports, predicts each record verdict
// and compares it field by field. Needs no RTL source beyond the DUT's port layout.
module crc_verdict_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [23:0]  i_req_data,    // data_byte[7:0], expected_crc[23:8]
    input  logic         i_req_last,    // record_end
    input  logic         i_req_user,    // byte_present
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  logic [143:0] i_rsp_data,    // computed_crc, checked, passed, failed counts,
                                        // mismatch_expected, mismatch_actual
    input  logic         i_rsp_user,    // crc_ok
    output int           o_fail_count,
    output int           o_pending,
    output int           o_verdicts,
    output int           o_passes
);

    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_GEN   = 16'h1021;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [15:0] crc;
        logic [31:0] checked;
        logic [31:0] passed;
        logic [31:0] failed;
        logic [15:0] bad_expected;
        logic [15:0] bad_actual;
    } t_verdict;

    t_verdict    verdict_q[$];
    logic [15:0] crc_run;
    logic [31:0] n_checked;
    logic [31:0] n_passed;
    logic [31:0] n_failed;
    logic [15:0] bad_expected;
    logic [15:0] bad_actual;
    int          fails    = 0;
    int          verdicts = 0;
    int          passes   = 0;

    // Bit-serial CCITT update, data bit against CRC msb.
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
        end
        return c;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == COUNT_TOP) ? v : v + 32'd1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        logic     ok;
        if (!i_rst_n) begin
            crc_run      = CRC_SEED;
            n_checked    = '0;
            n_passed     = '0;
            n_failed     = '0;
            bad_expected = '0;
            bad_actual   = '0;
            verdict_q.delete();
        end else begin
            // Compare first: a result never belongs to a request taken at the same edge.
            if (i_rsp_valid && i_rsp_ready) begin
                verdicts++;
                if (i_rsp_user) passes++;
                if (verdict_q.size() == 0) begin
                    $error("unexpected verdict: computed_crc 0x%0h", i_rsp_data[15:0]);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("crc_ok", 32'(want.ok), 32'(i_rsp_user));
                    check_field("computed_crc", 32'(want.crc), 32'(i_rsp_data[15:0]));
                    check_field("checked_count",     want.checked,      i_rsp_data[47:16]);
                    check_field("passed_count",      want.passed,       i_rsp_data[79:48]);
                    check_field("failed_count",      want.failed,       i_rsp_data[111:80]);
                    check_field("mismatch_expected", 32'(want.bad_expected),
                                32'(i_rsp_data[127:112]));
                    check_field("mismatch_actual", 32'(want.bad_actual),
                                32'(i_rsp_data[143:128]));
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_user) crc_run = crc_shift_byte(crc_run, i_req_data[7:0]);
                if (i_req_last) begin
                    ok        = (crc_run == i_req_data[23:8]);
                    n_checked = bump(n_checked);
                    if (ok) begin
                        n_passed = bump(n_passed);
                    end else begin
                        n_failed     = bump(n_failed);
                        bad_expected = i_req_data[23:8];
                        bad_actual   = crc_run;
                    end
                    verdict_q.push_back('{ok, crc_run, n_checked, n_passed, n_failed,
                                          bad_expected, bad_actual});
                    crc_run = CRC_SEED;
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
        o_verdicts   <= verdicts;
        o_passes     <= passes;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the record CRC checker testbench: clock, reset, record stimulus and receiver stalls.
// Depends on crcrc_pkg, crc16_record_checker_top and crc_verdict_monitor.
module testbench;

    localparam int          ITEM_TARGET  = 920;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [15:0] CHECK_CRC    = 16'h29B1;   // CRC of the ASCII string 123456789
    localparam int          RX_OPEN      = 0;
    localparam int          RX_ALTERNATE = 1;
    localparam int          RX_CHOPPY    = 2;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    int fail_count;
    int pending;
    int verdicts;
    int passes;
    int burst_left  = 0;
    int items_sent  = 0;
    int records     = 0;
    int idle_cycles = 0;
    int rx_tick     = 0;
    int rx_mode     = RX_OPEN;
    int rx_stall    = 0;

    crc16_record_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    crc_verdict_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_last   (s_axis_tlast),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_verdicts   (verdicts),
        .o_passes     (passes)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                             input logic [15:0] disk_crc);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tdata  <= {disk_crc, b};
        s_axis_tlast  <= last;
        s_axis_tuser  <= present;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
        if (last) records++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly correct disk CRCs; the rest single-bit corrupted or random.
    task automatic send_random_record(input int len);
        logic [15:0] good;
        logic [15:0] disk;
        logic [7:0]  b;
        logic        present;
        int          pick;
        good = crcrc_pkg::CRC_INIT;
        for (int i = 0; i < len; i++) begin
            b       = 8'($urandom_range(0, 255));
            present = ($urandom_range(0, 9) != 0);
            if (present) good = crcrc_pkg::crc_fold(good, b);
            send_item(b, present, 1'b0, 16'($urandom_range(0, 16'hFFFF)));
        end
        b       = 8'($urandom_range(0, 255));
        present = ($urandom_range(0, 3) != 0);
        if (present) good = crcrc_pkg::crc_fold(good, b);
        pick = $urandom_range(0, 9);
        if (pick < 6)      disk = good;
        else if (pick < 8) disk = good ^ (16'h0001 << $urandom_range(0, 15));
        else               disk = 16'($urandom_range(0, 16'hFFFF));
        send_item(b, present, 1'b1, disk);
    endtask

    initial begin
        string check_str;
        check_str     = "123456789";
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty records: seed value passes, anything else fails (first failure latch)
        send_item(8'h00, 1'b0, 1'b1, 16'hFFFF);
        send_item(8'hFF, 1'b0, 1'b1, 16'h0000);
        // standard check string passes; latched mismatch must hold
        for (int i = 0; i < 9; i++)
            send_item(check_str[i], 1'b1, i == 8, (i == 8) ? CHECK_CRC : 16'hFFFF);
        // extreme bytes with a skipped byte in the middle, wrong disk CRC
        send_item(8'h00, 1'b1, 1'b0, 16'h0000);
        send_item(8'hA5, 1'b0, 1'b0, 16'hFFFF);
        send_item(8'hFF, 1'b1, 1'b0, 16'h0000);
        send_item(8'hFF, 1'b1, 1'b1, 16'hFFFF);
        // single-byte records closed by a byte-carrying request
        send_item(8'h00, 1'b1, 1'b1, crcrc_pkg::crc_fold(crcrc_pkg::CRC_INIT, 8'h00));
        send_item(8'hFF, 1'b1, 1'b1, crcrc_pkg::crc_fold(crcrc_pkg::CRC_INIT, 8'hFF));
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) send_random_record($urandom_range(13, 40));
            else                           send_random_record($urandom_range(0, 12));
            // stray skipped bytes between records
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                          16'($urandom_range(0, 16'hFFFF)));
            if (records == 40 || $urandom_range(0, 59) == 0) drain_results();
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests over %0d records; %0d verdicts, %0d passing, %0d failing.",
                 items_sent, records, verdicts, passes, verdicts - passes);
        $display("Included empty records, skipped bytes, corrupted disk CRCs, gaps and stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("crc16_record_checker_top regression: pass");
        end else begin
            $display("crc16_record_checker_top regression: fail");
        end
        $finish;
    end

    // Receiver: open, alternating or choppy with random stall runs, the mode chosen at random.
    always @(negedge i_clk) begin
        if (rx_tick % 96 == 0) rx_mode = $urandom_range(RX_OPEN, RX_CHOPPY);
        rx_tick++;
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_ALTERNATE: begin
                    m_axis_tready <= rx_tick[0];
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 16);
                    m_axis_tready <= (rx_stall == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("crc16_record_checker_top regression: fail");
            $finish;
        end
    end

endmodule

/* sim.f */
hdl/crcrc_pkg.sv
hdl/crcrc_in_reg.sv
hdl/crcrc_core.sv
hdl/crc16_record_checker_top.sv
hdl/crcrc_checker.sv
dv/crc_verdict_monitor.sv
dv/testbench.sv
